// ===== rtl/core/vbat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the block address translator.
// Used by the front, back and top-level modules; depends on nothing.
package vbat_pkg;

   localparam int ENTRY_WIDTH = 47;
   localparam int OFF_WIDTH   = 47;
   localparam int LEN_WIDTH   = 26;

   localparam logic [4:0] BS_MIN = 5'd20;
   localparam logic [4:0] BS_MAX = 5'd28;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_INDEX = 2'd2;

   localparam logic [1:0] REG_BLOCK_SIZE_LOG2  = 2'd0;
   localparam logic [1:0] REG_CHUNK_RATIO_LOG2 = 2'd1;
   localparam logic [1:0] REG_DISK_SIZE        = 2'd2;
   localparam logic [1:0] REG_PARTITION_OFFSET = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [11:0] table_index;
      logic [63:0] table_entry;
      logic [45:0] read_offset;
      logic [25:0] read_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] file_offset;
      logic [25:0] segment_length;
      logic [24:0] buffer_position;
      logic        zero_fill;
      logic [2:0]  block_state;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  block_size_log2;
      logic [3:0]  chunk_ratio_log2;
      logic [46:0] disk_size;
      logic [45:0] partition_offset;
   } cfg_type;

   // classified command passed from the front to the back
   typedef struct packed {
      logic                   kind;
      logic                   wr_ok;
      logic [11:0]            table_index;
      logic [ENTRY_WIDTH-1:0] entry;
      logic [OFF_WIDTH-1:0]   read_offset;
      logic [LEN_WIDTH-1:0]   read_length;
   } cmd_type;

endpackage

// ===== rtl/core/vhdx_block_address_translator.sv =====
`timescale 1ns / 1ps
// Block address translator: translates virtual-disk reads into image-file segments
// through a block allocation table held in RAM.
// Request beats (req_*) carry either a table write (kind 0) or a read (kind 1).
// Response beats (rsp_*) carry one segment each; last marks the final beat of a request.
// A table write, a rejected read (status 1) or an empty read gives one beat.
// A read gives one beat per payload block touched; a block whose table index
// is past the table depth gives a status 2 beat that ends the request.
// Flow: the back end pops a request from the two-entry front queue when it is idle and
// the response register is free. Writes, rejects and empty reads are answered from the
// idle state; a read then steps through index, table RAM read and emit for each segment,
// paced by the RAM's registered read port.
// req_stall rises only when the front queue is full; the back end keeps working
// on the queue head and holds the response register while rsp_stall is high.
// Reset clears the queue, the sequencer and the config registers (block size 2^25,
// chunk ratio 2^11, disk size and partition offset 0). Table contents are
// undefined until written. The CSR port is APB-style at byte addresses 0, 8, 16, 24.
module vhdx_block_address_translator #(
   parameter int TABLE_DEPTH    = 4096,
   parameter int MAX_READ_BYTES = 33554432
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vbat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vbat_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   vbat_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic              head_valid;
   vbat_pkg::cmd_type head;
   logic              head_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            vbat_pkg::REG_BLOCK_SIZE_LOG2:  cfg_in.block_size_log2  = csr_pwdata[4:0];
            vbat_pkg::REG_CHUNK_RATIO_LOG2: cfg_in.chunk_ratio_log2 = csr_pwdata[3:0];
            vbat_pkg::REG_DISK_SIZE:        cfg_in.disk_size        = csr_pwdata[46:0];
            vbat_pkg::REG_PARTITION_OFFSET: cfg_in.partition_offset = csr_pwdata[45:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         vbat_pkg::REG_BLOCK_SIZE_LOG2:  csr_prdata = 64'(cfg_ff.block_size_log2);
         vbat_pkg::REG_CHUNK_RATIO_LOG2: csr_prdata = 64'(cfg_ff.chunk_ratio_log2);
         vbat_pkg::REG_DISK_SIZE:        csr_prdata = 64'(cfg_ff.disk_size);
         vbat_pkg::REG_PARTITION_OFFSET: csr_prdata = 64'(cfg_ff.partition_offset);
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size_log2  <= 5'd25;
         cfg_ff.chunk_ratio_log2 <= 4'd11;
         cfg_ff.disk_size        <= '0;
         cfg_ff.partition_offset <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vbat_front #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .MAX_READ_BYTES (MAX_READ_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   vbat_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

`ifndef SYNTHESIS
   // any error status ends the request
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != vbat_pkg::STATUS_OK) |-> rsp_data.last)
      else $error("error beat without last");

   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_fill |-> (rsp_data.file_offset == 64'd0))
      else $error("zero-fill beat with nonzero file offset");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.segment_length == 26'd0) |-> rsp_data.last)
      else $error("empty segment not marked last");

   a_index_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == vbat_pkg::STATUS_INDEX)
      |-> (rsp_data.segment_length == 26'd0) && !rsp_data.zero_fill)
      else $error("index error beat carries segment data");
`endif

endmodule

// ===== rtl/core/vbat_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vbat_ram #(
   parameter int WIDTH = 47,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vbat_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request beats, classifies them and queues commands.
// Depends on vbat_pkg.
module vbat_front #(
   parameter int TABLE_DEPTH    = 4096,
   parameter int MAX_READ_BYTES = 33554432
) (
   input  logic              clock,
   input  logic              reset,
   input  vbat_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  vbat_pkg::req_type req_data,
   output logic              head_valid,
   output vbat_pkg::cmd_type head,
   input  logic              head_pop
);

   vbat_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   vbat_pkg::cmd_type cmd;
   logic              push;

   always_comb begin
      cmd.kind        = req_data.kind;
      cmd.wr_ok       = (32'(req_data.table_index) < 32'(TABLE_DEPTH));
      cmd.table_index = req_data.table_index;
      cmd.entry       = {req_data.table_entry[63:20], req_data.table_entry[2:0]};
      cmd.read_offset = vbat_pkg::OFF_WIDTH'(req_data.read_offset)
                      + vbat_pkg::OFF_WIDTH'(cfg.partition_offset);
      // clamp long reads
      if (32'(req_data.read_length) > 32'(MAX_READ_BYTES)) begin
         cmd.read_length = vbat_pkg::LEN_WIDTH'(MAX_READ_BYTES);
      end else begin
         cmd.read_length = req_data.read_length;
      end
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/vbat_back.sv =====
`timescale 1ns / 1ps
// Back end: runs table writes and splits reads into per-block segments.
// Depends on vbat_pkg and vbat_ram.
module vbat_back #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  vbat_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  vbat_pkg::cmd_type head,
   output logic              head_pop,
   output logic              rsp_valid,
   output vbat_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);

   localparam int AW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_INDEX, S_FETCH, S_EMIT} state_type;

   state_type         state_ff, state_in;
   logic [46:0]       off_ff, off_in;
   logic [25:0]       rem_ff, rem_in;
   logic [25:0]       bpos_ff, bpos_in;
   logic [27:0]       bat_ff, bat_in;
   logic [27:0]       lo_ff, lo_in;
   logic [25:0]       cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vbat_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [4:0]        bs_eff;
   logic [26:0]       blk;
   logic [28:0]       span;
   logic [27:0]       lo;
   logic [47:0]       end_sum;
   logic              ram_we;
   logic              ram_re;
   logic [46:0]       ent;
   logic              zf;

   vbat_ram #(
      .WIDTH (vbat_pkg::ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(head.table_index)),
      .wr_data (head.entry),
      .rd_en   (ram_re),
      .rd_addr (AW'(bat_ff)),
      .rd_data (ent)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cfg.block_size_log2 < vbat_pkg::BS_MIN) begin
         bs_eff = vbat_pkg::BS_MIN;
      end else if (cfg.block_size_log2 > vbat_pkg::BS_MAX) begin
         bs_eff = vbat_pkg::BS_MAX;
      end else begin
         bs_eff = cfg.block_size_log2;
      end
   end

   assign blk     = 27'(off_ff >> bs_eff);
   assign lo      = off_ff[27:0] & 28'((29'd1 << bs_eff) - 29'd1);
   assign span    = (29'd1 << bs_eff) - 29'(lo);
   assign end_sum = 48'(head.read_offset) + 48'(head.read_length);
   assign zf      = (ent[46:3] == 44'd0);

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      bpos_in      = bpos_ff;
      bat_in       = bat_ff;
      lo_in        = lo_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      head_pop     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid && out_free) begin
               head_pop     = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.last = 1'b1;
               if (head.kind == vbat_pkg::KIND_WRITE) begin
                  ram_we       = head.wr_ok;
                  rsp_valid_in = 1'b1;
               end else if (end_sum > {1'b0, cfg.disk_size}) begin
                  rsp_data_in.status = vbat_pkg::STATUS_RANGE;
                  rsp_valid_in       = 1'b1;
               end else if (head.read_length == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  off_in   = head.read_offset;
                  rem_in   = head.read_length;
                  bpos_in  = '0;
                  state_in = S_INDEX;
               end
            end
         end
         S_INDEX: begin
            // skip the interleaved bitmap entry after each chunk
            bat_in = 28'(blk) + 28'(blk >> cfg.chunk_ratio_log2);
            lo_in  = lo;
            if (29'(rem_ff) < span) begin
               cur_in = rem_ff;
            end else begin
               cur_in = 26'(span);
            end
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (bat_ff >= 28'(TABLE_DEPTH)) begin
               if (out_free) begin
                  rsp_valid_in                = 1'b1;
                  rsp_data_in                 = '0;
                  rsp_data_in.status          = vbat_pkg::STATUS_INDEX;
                  rsp_data_in.buffer_position = bpos_ff[24:0];
                  rsp_data_in.last            = 1'b1;
                  rem_in                      = '0;
                  state_in                    = S_IDLE;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = vbat_pkg::STATUS_OK;
               rsp_data_in.file_offset     = zf ? 64'd0
                                           : {ent[46:3], 20'd0} + 64'(lo_ff);
               rsp_data_in.segment_length  = cur_ff;
               rsp_data_in.buffer_position = bpos_ff[24:0];
               rsp_data_in.zero_fill       = zf;
               rsp_data_in.block_state     = ent[2:0];
               rsp_data_in.last            = (rem_ff == cur_ff);
               off_in  = off_ff + 47'(cur_ff);
               rem_in  = rem_ff - cur_ff;
               bpos_in = bpos_ff + cur_ff;
               state_in = (rem_ff == cur_ff) ? S_IDLE : S_INDEX;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      rem_ff      <= rem_in;
      bpos_ff     <= bpos_in;
      bat_ff      <= bat_in;
      lo_ff       <= lo_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/vhdx_block_address_translator_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the block address translator: directed and random request beats through
// a valid/stall channel, CSR phases over APB, and an in-order check of response beats.
// Depends on vbat_pkg and the vhdx_block_address_translator RTL.
module vhdx_block_address_translator_tb;

   localparam int          TABLE_DEPTH    = 4096;
   localparam logic [63:0] MAX_READ_BYTES = 64'd33554432;

   // Own copy of the allocation table and registers; splits reads into expected segments.
   class bat_translation_check;
      logic [46:0]       bat_mem     [TABLE_DEPTH];
      bit                bat_written [TABLE_DEPTH];
      logic [4:0]        block_size_log2  = 5'd25;
      logic [3:0]        chunk_ratio_log2 = 4'd11;
      logic [46:0]       disk_size        = '0;
      logic [45:0]       partition_offset = '0;
      vbat_pkg::rsp_type new_segments [$];
      vbat_pkg::rsp_type segments_due [$];
      int                errors, requests, table_writes, beats_seen;
      int                range_rejects, index_stops, zero_fills, most_beats;

      function void set_register(logic [1:0] idx, logic [63:0] value);
         case (idx)
            vbat_pkg::REG_BLOCK_SIZE_LOG2:  block_size_log2  = value[4:0];
            vbat_pkg::REG_CHUNK_RATIO_LOG2: chunk_ratio_log2 = value[3:0];
            vbat_pkg::REG_DISK_SIZE:        disk_size        = value[46:0];
            vbat_pkg::REG_PARTITION_OFFSET: partition_offset = value[45:0];
            default:                        ;
         endcase
      endfunction

      function int unsigned block_shift();
         if (block_size_log2 < vbat_pkg::BS_MIN) return 32'(vbat_pkg::BS_MIN);
         if (block_size_log2 > vbat_pkg::BS_MAX) return 32'(vbat_pkg::BS_MAX);
         return 32'(block_size_log2);
      endfunction

      function void add_segment(logic [1:0] status, logic [63:0] foff, logic [63:0] len,
                                logic [63:0] bpos, bit zf, logic [2:0] st, bit last);
         vbat_pkg::rsp_type b;
         b.status          = status;
         b.file_offset     = foff;
         b.segment_length  = len[25:0];
         b.buffer_position = bpos[24:0];
         b.zero_fill       = zf;
         b.block_state     = st;
         b.last            = last;
         new_segments.push_back(b);
      endfunction

      // Returns 0 when the read would look up a table entry never written.
      function bit split_read(vbat_pkg::req_type r);
         logic [63:0] off, remaining, bsize, lo, blk, bat, cur, foff, bpos;
         logic [46:0] ent;
         int unsigned shift;
         new_segments.delete();
         shift     = block_shift();
         bsize     = 64'd1 << shift;
         off       = 64'(r.read_offset) + 64'(partition_offset);
         remaining = 64'(r.read_length);
         bpos      = '0;
         if (remaining > MAX_READ_BYTES) remaining = MAX_READ_BYTES;
         if (off + remaining > 64'(disk_size)) begin
            add_segment(vbat_pkg::STATUS_RANGE, '0, '0, '0, 1'b0, 3'd0, 1'b1);
            return 1'b1;
         end
         if (remaining == 0) begin
            add_segment(vbat_pkg::STATUS_OK, '0, '0, '0, 1'b0, 3'd0, 1'b1);
            return 1'b1;
         end
         while (remaining != 0) begin
            lo  = off & (bsize - 64'd1);
            blk = off >> shift;
            // skip the bitmap entry interleaved after each chunk of data entries
            bat = blk + (blk >> chunk_ratio_log2);
            if (bat >= 64'(TABLE_DEPTH)) begin
               add_segment(vbat_pkg::STATUS_INDEX, '0, '0, bpos, 1'b0, 3'd0, 1'b1);
               return 1'b1;
            end
            if (!bat_written[bat]) return 1'b0;
            ent  = bat_mem[bat];
            foff = {ent[46:3], 20'd0};
            cur  = bsize - lo;
            if (remaining < cur) cur = remaining;
            off       += cur;
            remaining -= cur;
            add_segment(vbat_pkg::STATUS_OK, (foff == 0) ? 64'd0 : foff + lo, cur, bpos,
                        foff == 0, ent[2:0], remaining == 0);
            bpos += cur;
         end
         return 1'b1;
      endfunction

      function void note_request(vbat_pkg::req_type r);
         requests++;
         if (r.kind == vbat_pkg::KIND_WRITE) begin
            table_writes++;
            bat_mem[r.table_index]     = {r.table_entry[63:20], r.table_entry[2:0]};
            bat_written[r.table_index] = 1'b1;
            new_segments.delete();
            add_segment(vbat_pkg::STATUS_OK, '0, '0, '0, 1'b0, 3'd0, 1'b1);
         end else begin
            void'(split_read(r));
         end
         foreach (new_segments[i]) begin
            if (new_segments[i].status == vbat_pkg::STATUS_RANGE) range_rejects++;
            else if (new_segments[i].status == vbat_pkg::STATUS_INDEX) index_stops++;
            if (new_segments[i].zero_fill) zero_fills++;
            segments_due.push_back(new_segments[i]);
         end
         if (new_segments.size() > most_beats) most_beats = new_segments.size();
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(vbat_pkg::rsp_type got);
         vbat_pkg::rsp_type want;
         beats_seen++;
         if (segments_due.size() == 0) begin
            $error("response beat with nothing outstanding: %p", got);
            errors++;
            return;
         end
         want = segments_due.pop_front();
         compare("status", 64'(want.status), 64'(got.status));
         compare("file_offset", want.file_offset, got.file_offset);
         compare("segment_length", 64'(want.segment_length), 64'(got.segment_length));
         compare("buffer_position", 64'(want.buffer_position), 64'(got.buffer_position));
         compare("zero_fill", 64'(want.zero_fill), 64'(got.zero_fill));
         compare("block_state", 64'(want.block_state), 64'(got.block_state));
         compare("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

   logic              clock, reset;
   logic              req_valid, req_stall, rsp_valid, rsp_stall;
   vbat_pkg::req_type req_data;
   vbat_pkg::rsp_type rsp_data;
   logic              csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0]        csr_paddr;
   logic [63:0]       csr_pwdata, csr_prdata;

   bat_translation_check xlate = new();
   int src_idle_pct  = 33;
   int snk_idle_pct  = 33;
   int holdoff_asks  = 0;

   vhdx_block_address_translator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #1_000_000;
      $display("vhdx_block_address_translator regression: fail");
      $finish;
   end

   initial begin : response_sink
      int holdoff_left;
      int holdoff_seen;
      holdoff_left = 0;
      holdoff_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) xlate.check_result(rsp_data);
         if (holdoff_seen != holdoff_asks) begin
            holdoff_seen = holdoff_asks;
            holdoff_left = 400;
         end
         if (holdoff_left > 0) holdoff_left--;
         rsp_stall <= (holdoff_left > 0) || (int'($urandom_range(99)) < snk_idle_pct);
      end
   end

   function automatic vbat_pkg::req_type make_read(logic [45:0] offset,
                                                   logic [25:0] length);
      vbat_pkg::req_type r;
      r.kind        = vbat_pkg::KIND_READ;
      r.table_index = 12'($urandom);
      r.table_entry = {$urandom, $urandom};
      r.read_offset = offset;
      r.read_length = length;
      return r;
   endfunction

   function automatic vbat_pkg::req_type make_write(logic [11:0] idx, logic [63:0] entry);
      vbat_pkg::req_type r;
      r.kind        = vbat_pkg::KIND_WRITE;
      r.table_index = idx;
      r.table_entry = entry;
      r.read_offset = 46'({$urandom, $urandom});
      r.read_length = 26'($urandom);
      return r;
   endfunction

   // Mostly reads aimed at written table entries; the rest random noise.
   function automatic vbat_pkg::req_type random_read();
      vbat_pkg::req_type r;
      logic [63:0]       blk, voff, bsize, part;
      logic [45:0]       offset;
      logic [25:0]       length;
      int unsigned       shift, cr, t;
      shift = xlate.block_shift();
      cr    = 32'(xlate.chunk_ratio_log2);
      part  = 64'(xlate.partition_offset);
      bsize = 64'd1 << shift;
      repeat (64) begin
         offset = 46'({$urandom, $urandom});
         length = 26'($urandom);
         if ($urandom_range(99) < 80) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: t = $urandom_range(40);
               6, 7, 8:          t = $urandom_range(TABLE_DEPTH - 1, TABLE_DEPTH - 16);
               default:          t = $urandom_range(TABLE_DEPTH - 1);
            endcase
            blk = (64'(t) << cr) / ((64'd1 << cr) + 64'd1);
            case ($urandom_range(3))
               0:       voff = blk << shift;
               1:       voff = (blk << shift) + bsize - 64'd1 - 64'($urandom_range(15));
               default: voff = (blk << shift) + ({$urandom, $urandom} & (bsize - 64'd1));
            endcase
            case ($urandom_range(9))
               0:          length = '0;
               1, 2, 3, 4: length = 26'($urandom_range(1, 4096));
               5, 6, 7:    length = 26'($urandom_range(1, 1 << $urandom_range(25, 12)));
               8:          length = MAX_READ_BYTES[25:0];
               default:    length = 26'($urandom_range(26'h3FF_FFFF, 26'h200_0001));
            endcase
            if (voff >= part) offset = 46'(voff - part);
         end
         r = make_read(offset, length);
         if (xlate.split_read(r)) return r;
      end
      return make_read(46'd0, 26'd0);
   endfunction

   task automatic send_request(vbat_pkg::req_type item);
      while (int'($urandom_range(99)) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      xlate.note_request(item);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (xlate.segments_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      logic [63:0] mask;
      case (idx)
         vbat_pkg::REG_BLOCK_SIZE_LOG2:  mask = 64'h1F;
         vbat_pkg::REG_CHUNK_RATIO_LOG2: mask = 64'hF;
         vbat_pkg::REG_DISK_SIZE:        mask = (64'd1 << 47) - 64'd1;
         default:                        mask = (64'd1 << 46) - 64'd1;
      endcase
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      xlate.set_register(idx, value);
      // read the register back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      xlate.compare("csr readback", value & mask, csr_prdata & mask);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(logic [63:0] bs, logic [63:0] cr, logic [63:0] disk,
                            logic [63:0] part);
      drain_responses();
      csr_write(vbat_pkg::REG_BLOCK_SIZE_LOG2, bs);
      csr_write(vbat_pkg::REG_CHUNK_RATIO_LOG2, cr);
      csr_write(vbat_pkg::REG_DISK_SIZE, disk);
      csr_write(vbat_pkg::REG_PARTITION_OFFSET, part);
   endtask

   task automatic run_random(int count);
      vbat_pkg::req_type r;
      logic [11:0]       idx;
      logic [63:0]       entry;
      repeat (count) begin
         if ($urandom_range(99) < 25) begin
            idx   = $urandom_range(1) ? 12'($urandom_range(71)) : 12'($urandom);
            entry = ($urandom_range(3) == 0) ? 64'($urandom_range(7)) : {$urandom, $urandom};
            r = make_write(idx, entry);
         end else begin
            r = random_read();
         end
         send_request(r);
         // now and then let everything drain before going on
         if ($urandom_range(99) < 4) drain_responses();
      end
   endtask

   initial begin : stimulus
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: disk size 0, so only an empty read fits
      send_request(make_read(46'd0, 26'd0));
      send_request(make_read(46'd0, 26'd1));
      send_request(make_read('1, '1));

      for (int i = 0; i < 72; i++)
         send_request(make_write(12'(i), (i % 8 == 5) ? 64'($urandom_range(7))
                                                      : {$urandom, $urandom}));
      for (int i = TABLE_DEPTH - 16; i < TABLE_DEPTH; i++)
         send_request(make_write(12'(i), {$urandom, $urandom}));
      send_request(make_write(12'd0, '1));
      send_request(make_write(12'd2, 64'd5));

      configure(64'd28, 64'd0, 64'd1 << 46, 64'd0);
      // offset wraps in block 0, block 1 maps to the zero-filled entry
      send_request(make_read(46'h0FFF_FFFF, 26'd2));
      send_request(make_read(46'd0, MAX_READ_BYTES[25:0]));
      send_request(make_read(46'd0, '1));
      // runs off the end of the table after 16 bytes
      send_request(make_read((46'd2047 << 28) + 46'h0FFF_FFF0, 26'd32));
      send_request(make_read('1, 26'd2));
      send_request(make_read('1, 26'd1));
      send_request(make_read(46'h1234_5678, 26'd0));
      run_random(10);

      configure(64'd20, 64'd11, 64'd1 << 46, 64'd0);
      run_random(20);

      src_idle_pct = 0;
      snk_idle_pct = 0;
      configure(64'd0, 64'($urandom_range(10, 1)), (64'd1 << 30) + ({$urandom, $urandom} &
                ((64'd1 << 40) - 64'd1)), 64'($urandom_range(20'hFFFFF)));
      run_random(20);
      src_idle_pct = 33;
      snk_idle_pct = 33;

      configure(64'd31, 64'd15, (64'd1 << 47) - 64'd1, (64'd1 << 46) - 64'd1);
      run_random(8);

      configure(64'($urandom_range(27, 21)), 64'($urandom_range(11)), 64'd1 << 46,
                64'($urandom));
      // hold the response side off while requests keep coming
      holdoff_asks++;
      src_idle_pct = 0;
      run_random(20);
      src_idle_pct = 33;
      run_random(10);

      configure(64'd25, 64'd11, 64'd0, 64'd0);
      run_random(7);

      drain_responses();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests (%0d table writes) and checked %0d response beats.",
               xlate.requests, xlate.table_writes, xlate.beats_seen);
      $display("Saw %0d disk-size rejects, %0d table-end stops, %0d zero-fill beats,",
               xlate.range_rejects, xlate.index_stops, xlate.zero_fills);
      $display("and at most %0d beats for one request.", xlate.most_beats);
      if (xlate.errors == 0) begin
         $display("vhdx_block_address_translator regression: pass");
      end else begin
         $display("vhdx_block_address_translator regression: fail");
      end
      $finish;
   end

endmodule
